/* sv/jkse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jkse_pkg;

    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;

    // result status codes
    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef enum logic [3:0] {
        PH_SEARCH    = 4'd0,
        PH_KEY       = 4'd1,
        PH_AFTER_KEY = 4'd2,
        PH_AFTER_COL = 4'd3,
        PH_VALUE     = 4'd4,
        PH_ESCAPE    = 4'd5,
        PH_DONE      = 4'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] value_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    // results produced by one text byte: up to two
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_step;

endpackage

`default_nettype wire

/* sv/jkse_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface jkse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface jkse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output value_byte, output status, output last, input ready);
    modport sink   (input valid, input value_byte, input status, input last, output ready);
endinterface

interface jkse_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jkse_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/jkse_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none

module jkse_fsm #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_byte,
    input  wire logic [63:0]     i_key_lo,
    input  wire logic [63:0]     i_key_hi,
    input  wire logic [4:0]      i_key_len,
    output jkse_pkg::t_step      o_step
);

    localparam int         PosW   = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [4:0] MaxLen = 5'(MAX_KEY_BYTES);

    typedef struct packed {
        jkse_pkg::t_phase phase;
        logic [PosW-1:0]  pos;
    } t_match;

    jkse_pkg::t_phase r_phase, n_phase;
    logic [PosW-1:0]  r_pos, n_pos;
    logic             r_blank, n_blank;

    logic [127:0]     key_all;
    logic [4:0]       key_used;
    logic [4:0]       pos_ext;
    logic [7:0]       kb_cur;
    logic [7:0]       kb_first;
    logic             blank;
    t_match           m;

    function automatic t_match match_key(input logic [7:0] b, input logic [PosW-1:0] pos,
                                         input logic [7:0] kb, input logic [4:0] len);
        t_match r;
        r.phase = jkse_pkg::PH_KEY;
        r.pos   = pos;
        if (5'(pos) < len) begin
            if (b == kb) begin
                r.pos = pos + 1'b1;
            end else if (b == jkse_pkg::CH_QUOTE) begin
                r.pos = '0;
            end else begin
                r.phase = jkse_pkg::PH_SEARCH;
            end
        end else if (b == jkse_pkg::CH_QUOTE) begin
            r.phase = jkse_pkg::PH_AFTER_KEY;
        end else begin
            r.phase = jkse_pkg::PH_SEARCH;
        end
        return r;
    endfunction

    assign key_all  = {i_key_hi, i_key_lo};
    assign key_used = (i_key_len > MaxLen) ? MaxLen : i_key_len;
    assign pos_ext  = 5'(r_pos);
    assign kb_cur   = key_all[{pos_ext[3:0], 3'b000} +: 8];
    assign kb_first = key_all[7:0];
    assign blank    = (i_byte == jkse_pkg::CH_SPACE) || (i_byte == jkse_pkg::CH_TAB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jkse_pkg::PH_SEARCH;
            r_pos   <= '0;
            r_blank <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_blank <= n_blank;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_blank = r_blank;
        m       = '0;
        o_step  = '0;

        if (i_byte == jkse_pkg::CH_NUL) begin
            // end of document: report unless already done, then rearm for the next one
            unique case (r_phase)
                jkse_pkg::PH_VALUE: begin
                    o_step.cnt = 2'd1;
                    o_step.r0  = '{8'h00, jkse_pkg::ST_DONE, 1'b1};
                end
                jkse_pkg::PH_ESCAPE: begin
                    o_step.cnt = 2'd2;
                    o_step.r0  = '{jkse_pkg::CH_BSLASH, jkse_pkg::ST_BYTE, 1'b0};
                    o_step.r1  = '{8'h00, jkse_pkg::ST_DONE, 1'b1};
                end
                jkse_pkg::PH_DONE: begin
                    o_step.cnt = 2'd0;
                end
                default: begin
                    o_step.cnt = 2'd1;
                    o_step.r0  = '{8'h00, jkse_pkg::ST_NONE, 1'b1};
                end
            endcase
            n_phase = jkse_pkg::PH_SEARCH;
            n_pos   = '0;
            n_blank = 1'b0;
        end else begin
            unique case (r_phase)
                jkse_pkg::PH_SEARCH: begin
                    if (i_byte == jkse_pkg::CH_QUOTE) begin
                        n_phase = jkse_pkg::PH_KEY;
                        n_pos   = '0;
                    end
                end
                jkse_pkg::PH_KEY: begin
                    m       = match_key(i_byte, r_pos, kb_cur, key_used);
                    n_phase = m.phase;
                    n_pos   = m.pos;
                    if (m.phase == jkse_pkg::PH_AFTER_KEY) begin
                        n_blank = 1'b0;
                    end
                end
                jkse_pkg::PH_AFTER_KEY: begin
                    priority if (blank) begin
                        n_blank = 1'b1;
                    end else if (i_byte == jkse_pkg::CH_COLON) begin
                        n_phase = jkse_pkg::PH_AFTER_COL;
                    end else if (!r_blank) begin
                        // closing quote of the key reopens a candidate
                        m       = match_key(i_byte, '0, kb_first, key_used);
                        n_phase = m.phase;
                        n_pos   = m.pos;
                        if (m.phase == jkse_pkg::PH_AFTER_KEY) begin
                            n_blank = 1'b0;
                        end
                    end else if (i_byte == jkse_pkg::CH_QUOTE) begin
                        n_phase = jkse_pkg::PH_KEY;
                        n_pos   = '0;
                    end else begin
                        n_phase = jkse_pkg::PH_SEARCH;
                    end
                end
                jkse_pkg::PH_AFTER_COL: begin
                    if (i_byte == jkse_pkg::CH_QUOTE) begin
                        n_phase = jkse_pkg::PH_VALUE;
                    end else if (!blank) begin
                        o_step.cnt = 2'd1;
                        o_step.r0  = '{8'h00, jkse_pkg::ST_NONE, 1'b1};
                        n_phase    = jkse_pkg::PH_DONE;
                    end
                end
                jkse_pkg::PH_VALUE: begin
                    if (i_byte == jkse_pkg::CH_QUOTE) begin
                        o_step.cnt = 2'd1;
                        o_step.r0  = '{8'h00, jkse_pkg::ST_DONE, 1'b1};
                        n_phase    = jkse_pkg::PH_DONE;
                    end else if (i_byte == jkse_pkg::CH_BSLASH) begin
                        n_phase = jkse_pkg::PH_ESCAPE;
                    end else begin
                        o_step.cnt = 2'd1;
                        o_step.r0  = '{i_byte, jkse_pkg::ST_BYTE, 1'b0};
                    end
                end
                jkse_pkg::PH_ESCAPE: begin
                    o_step.cnt = 2'd1;
                    o_step.r0  = '{i_byte, jkse_pkg::ST_BYTE, 1'b0};
                    if (i_byte == jkse_pkg::CH_LC_N) begin
                        o_step.r0.value_byte = jkse_pkg::CH_LF;
                    end else if (i_byte == jkse_pkg::CH_LC_T) begin
                        o_step.r0.value_byte = jkse_pkg::CH_TAB;
                    end else if (i_byte == jkse_pkg::CH_LC_R) begin
                        o_step.r0.value_byte = jkse_pkg::CH_CR;
                    end
                    n_phase = jkse_pkg::PH_VALUE;
                end
                jkse_pkg::PH_DONE: begin
                    n_phase = jkse_pkg::PH_DONE;
                end
                default: begin
                    n_phase = jkse_pkg::PH_SEARCH;
                    n_pos   = '0;
                    n_blank = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/json_key_string_extractor.sv */
// Flow: a text byte taken into the input register is parsed there, and its results
//   are written into the result queue, from which they are offered on o_res.
// Throughput: one text byte per cycle while the queue holds two results or fewer;
//   its four entries absorb the one case (escape pending at end of text) of two results.
// Reset: synchronous, active low; parser returns to quote search, key registers
//   and length clear to zero, result queue empties.
`timescale 1ns / 1ps
`default_nettype none

module json_key_string_extractor #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    jkse_in_if.sink     i_text,
    jkse_out_if.source  o_res,
    jkse_cfg_if.sink    i_cfg
);

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    logic [63:0]       r_key_lo;
    logic [63:0]       r_key_hi;
    logic [4:0]        r_key_len;

    logic              r_in_vld;
    logic [7:0]        r_in_byte;

    jkse_pkg::t_result r_q [QDepth];
    logic [QPtrW-1:0]  r_wp, r_rp;
    logic [QPtrW:0]    r_cnt;

    jkse_pkg::t_step   step;
    jkse_pkg::t_result head;
    logic              advance;
    logic              pop;
    logic [1:0]        push_n;
    logic [QPtrW-1:0]  wp_next;

    // ---- configuration ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                jkse_pkg::CFG_KEY_LO:  r_key_lo  <= i_cfg.data;
                jkse_pkg::CFG_KEY_HI:  r_key_hi  <= i_cfg.data;
                jkse_pkg::CFG_KEY_LEN: r_key_len <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    assign advance      = r_in_vld && (r_cnt <= (QPtrW+1)'(QDepth - 2));
    assign i_text.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_text.ready) begin
            r_in_vld <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    jkse_fsm #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_byte    (r_in_byte),
        .i_key_lo  (r_key_lo),
        .i_key_hi  (r_key_hi),
        .i_key_len (r_key_len),
        .o_step    (step)
    );

    // ---- result queue ----
    assign push_n  = advance ? step.cnt : 2'd0;
    assign wp_next = r_wp + 1'b1;
    assign head    = r_q[r_rp];
    assign pop     = o_res.valid && o_res.ready;

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.value_byte = head.value_byte;
    assign o_res.status     = head.status;
    assign o_res.last       = head.last;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wp] <= step.r0;
        end
        if (push_n == 2'd2) begin
            r_q[wp_next] <= step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QPtrW'(push_n);
            r_rp  <= r_rp + QPtrW'(pop);
            r_cnt <= r_cnt + (QPtrW+1)'(push_n) - (QPtrW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

/* sv/jkse_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module jkse_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_value_byte,
    input wire logic [1:0] i_status,
    input wire logic       i_last
);

    // a stalled beat keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_value_byte) && $stable(i_status) && $stable(i_last))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == jkse_pkg::ST_BYTE) || (i_status == jkse_pkg::ST_DONE)
                        || (i_status == jkse_pkg::ST_NONE))
        else $error("undefined status code");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_status != jkse_pkg::ST_BYTE)))
        else $error("last does not match terminal status");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != jkse_pkg::ST_BYTE) |-> (i_value_byte == 8'h00))
        else $error("terminal beat carries a nonzero byte");

endmodule

bind json_key_string_extractor jkse_checker u_jkse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_value_byte (o_res.value_byte),
    .i_status     (o_res.status),
    .i_last       (o_res.last)
);

`default_nettype wire
